// ----- rtl/kdmh_pkg.sv -----
// Shared types and constants for the key debouncer with multi-stage hold.
// No dependencies; imported by every module of the block.
package kdmh_pkg;

    localparam int unsigned KEY_LINES_DEF = 6;
    localparam int unsigned CFG_W         = 8;
    localparam int unsigned CFG_ADDR_W    = 2;
    localparam int unsigned STAGE_W       = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD1  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD2  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD3  = 2'd3;

    localparam logic [CFG_W-1:0] SETTLE_RST = 8'd10;
    localparam logic [CFG_W-1:0] HOLD1_RST  = 8'd150;
    localparam logic [CFG_W-1:0] HOLD2_RST  = 8'd100;
    localparam logic [CFG_W-1:0] HOLD3_RST  = 8'd150;

    localparam logic [STAGE_W-1:0] STAGE_MAX = 2'd3;

    // Operation codes carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] first_hold_ticks;
        logic [CFG_W-1:0] second_hold_ticks;
        logic [CFG_W-1:0] third_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic               settled;
        logic               key_down;
        logic               hold_event;
        logic [STAGE_W-1:0] hold_level;
        logic               code_changed;
    } t_flags;

endpackage

// ----- rtl/key_debounce_multi_hold_core.sv -----
// Key debouncer with three long-press stages: top level with stream channels.
// Depends on kdmh_pkg, kdmh_cfg and kdmh_step.
//
// Usage:
//   Slave channel s_axis_*: one request per poll tick or key-edge interrupt.
//   tuser carries the operation (0 tick, 1 edge), tdata the sampled key lines
//   (active low, all ones = no key).
//   Master channel m_axis_*: exactly one result per request, in order.
//   Config port: i_cfg_we/i_cfg_addr/i_cfg_wdata writes settle and hold
//   reloads; write only while no request is in flight.
// Timing: a request is registered at acceptance; the state update and the
//   result register load happen together once the result register is free.
//   The single state update stage sets the rate: one request per cycle,
//   sustained while m_axis_tready stays high.
// Reset: synchronous, active low; state goes to no key, no scan, hold 0,
//   config to 10/150/100/150, both channels empty.
// Stall: when m_axis_tready is low the result holds; one more request may
//   be taken into the input register, then s_axis_tready drops.
module key_debounce_multi_hold_core import kdmh_pkg::*; #(
    parameter int unsigned KEY_LINES = KEY_LINES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [KEY_LINES-1:0] key_lines, zero padded
    input  logic [((KEY_LINES + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // [0] operation
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // stable_code, code_changed, hold_level[2], hold_event, key_down,
    // settled, zero padded (lowest bit first)
    output logic [((KEY_LINES + $bits(t_flags) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]             i_cfg_wdata
);

    localparam int unsigned RES_W  = KEY_LINES + $bits(t_flags);
    localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8;

    t_cfg                 cfg;
    t_flags               flags;
    logic [KEY_LINES-1:0] code;

    logic                 r_in_valid;
    logic                 r_in_op;
    logic [KEY_LINES-1:0] r_in_keys;
    logic                 r_out_valid;
    logic [RES_W-1:0]     r_out_data;
    logic                 out_free;
    logic                 advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_keys <= s_axis_tdata[KEY_LINES-1:0];
        end
    end

    kdmh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    kdmh_step #(
        .KEY_LINES (KEY_LINES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_op    (r_in_op),
        .i_keys  (r_in_keys),
        .i_cfg   (cfg),
        .o_code  (code),
        .o_flags (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {flags, code};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);

endmodule

// ----- rtl/kdmh_cfg.sv -----
// Configuration register file: settle and three hold timer reloads.
// Depends on kdmh_pkg.
module kdmh_cfg import kdmh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [CFG_W-1:0]      i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks      <= SETTLE_RST;
            r_cfg.first_hold_ticks  <= HOLD1_RST;
            r_cfg.second_hold_ticks <= HOLD2_RST;
            r_cfg.third_hold_ticks  <= HOLD3_RST;
        end else if (i_we) begin
            case (i_addr)
                REG_SETTLE: r_cfg.settle_ticks      <= i_wdata;
                REG_HOLD1:  r_cfg.first_hold_ticks  <= i_wdata;
                REG_HOLD2:  r_cfg.second_hold_ticks <= i_wdata;
                REG_HOLD3:  r_cfg.third_hold_ticks  <= i_wdata;
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/kdmh_step.sv -----
// Debounce and hold state, updated once for each accepted request.
// Depends on kdmh_pkg.
module kdmh_step import kdmh_pkg::*; #(
    parameter int unsigned KEY_LINES = KEY_LINES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_op,
    input  logic [KEY_LINES-1:0] i_keys,
    input  t_cfg                 i_cfg,
    output logic [KEY_LINES-1:0] o_code,
    output t_flags               o_flags
);

    localparam logic [KEY_LINES-1:0] NO_KEY = {KEY_LINES{1'b1}};

    logic [KEY_LINES-1:0] r_cand, n_cand;
    logic [KEY_LINES-1:0] r_acc, n_acc;
    logic [CFG_W-1:0]     r_settle, n_settle;
    logic [CFG_W-1:0]     r_hold, n_hold;
    logic [STAGE_W-1:0]   r_stage, n_stage;
    logic                 r_active, n_active;
    logic                 r_done, n_done;
    logic                 r_pressed, n_pressed;
    logic                 changed, hold_ev;

    always_comb begin
        n_cand    = r_cand;
        n_acc     = r_acc;
        n_settle  = r_settle;
        n_hold    = r_hold;
        n_stage   = r_stage;
        n_active  = r_active;
        n_done    = r_done;
        n_pressed = r_pressed;
        changed   = 1'b0;
        hold_ev   = 1'b0;
        if (i_op == OP_EDGE) begin
            // edge while a scan runs is ignored
            if (!r_active) begin
                n_cand    = i_keys;
                n_active  = 1'b1;
                n_done    = 1'b0;
                n_settle  = i_cfg.settle_ticks;
                n_pressed = (i_keys != NO_KEY);
                n_hold    = '0;
                n_stage   = '0;
            end
        end else if (i_keys == r_cand) begin
            if (r_settle != '0) begin
                n_settle = r_settle - 1'b1;
                if (r_settle == CFG_W'(1)) begin
                    n_done   = 1'b1;
                    n_active = 1'b0;
                    if (r_acc != r_cand) begin
                        n_acc   = r_cand;
                        changed = 1'b1;
                        if (i_keys == NO_KEY) begin
                            n_hold    = '0;
                            n_pressed = 1'b0;
                        end else begin
                            n_hold    = i_cfg.first_hold_ticks;
                            n_pressed = 1'b1;
                        end
                    end
                end
            end else if (r_done && !r_active && r_pressed && r_stage != STAGE_MAX) begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                    if (r_hold == CFG_W'(1)) begin
                        n_stage = r_stage + 1'b1;
                        hold_ev = 1'b1;
                        // reaching the last stage leaves the timer at zero
                        if (r_stage == STAGE_W'(0)) begin
                            n_hold = i_cfg.second_hold_ticks;
                        end else if (r_stage == STAGE_W'(1)) begin
                            n_hold = i_cfg.third_hold_ticks;
                        end
                    end
                end
            end
        end else begin
            n_cand   = i_keys;
            n_settle = i_cfg.settle_ticks;
            n_hold   = '0;
            n_stage  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand    <= '0;
            r_acc     <= NO_KEY;
            r_settle  <= '0;
            r_hold    <= '0;
            r_stage   <= '0;
            r_active  <= 1'b0;
            r_done    <= 1'b0;
            r_pressed <= 1'b0;
        end else if (i_en) begin
            r_cand    <= n_cand;
            r_acc     <= n_acc;
            r_settle  <= n_settle;
            r_hold    <= n_hold;
            r_stage   <= n_stage;
            r_active  <= n_active;
            r_done    <= n_done;
            r_pressed <= n_pressed;
        end
    end

    assign o_code               = n_acc;
    assign o_flags.code_changed = changed;
    assign o_flags.hold_level   = n_stage;
    assign o_flags.hold_event   = hold_ev;
    assign o_flags.key_down     = n_pressed;
    assign o_flags.settled      = n_done;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for key_debounce_multi_hold_core: a directed stimulus table, then
// randomized press/hold/bounce sequences checked against a debounce predictor.
// Depends on kdmh_pkg and the block's RTL.
module tb;
    import kdmh_pkg::*;

    localparam int         IN_W            = 8;
    localparam int         OUT_W           = 16;
    localparam logic [5:0] NO_KEY          = 6'h3f;
    localparam int         LATENCY         = 2;
    localparam int         HOLD_OFF_CYCLES = 64;
    localparam int         DIR_ROWS        = 24;
    localparam int         MAX_REPORTS     = 50;

    // Result layout of m_axis_tdata, lowest bit last in this list.
    typedef struct packed {
        logic [3:0] pad;
        logic       settled;
        logic       key_down;
        logic       hold_event;
        logic [1:0] hold_level;
        logic       code_changed;
        logic [5:0] stable_code;
    } t_key_result;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [5:0]  keys;
        t_cfg        cfg;
        t_key_result want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // [5:0] key_lines
    logic              s_axis_tuser;   // [0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // stable_code, code_changed, hold_level,
                                       // hold_event, key_down, settled
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    // predictor state
    t_cfg       pred_cfg;
    logic [5:0] cand_code;
    logic [5:0] acc_code;
    logic [7:0] settle_cnt;
    logic [7:0] hold_cnt;
    logic [1:0] hold_stage;
    logic       scanning;
    logic       scan_finished;
    logic       pressed;

    t_key_result expected_results[$];
    int          errors      = 0;
    int          items_left  = 0;
    int          burst_left  = 0;
    bit          no_gaps     = 1'b0;
    bit          hold_off_req = 1'b0;

    key_debounce_multi_hold_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_cfg mk_cfg(input int s, input int h1, input int h2, input int h3);
        t_cfg c;
        c.settle_ticks      = s[7:0];
        c.first_hold_ticks  = h1[7:0];
        c.second_hold_ticks = h2[7:0];
        c.third_hold_ticks  = h3[7:0];
        return c;
    endfunction

    task automatic debounce_reset();
        pred_cfg      = mk_cfg(SETTLE_RST, HOLD1_RST, HOLD2_RST, HOLD3_RST);
        cand_code     = 6'h00;
        acc_code      = NO_KEY;
        settle_cnt    = 8'd0;
        hold_cnt      = 8'd0;
        hold_stage    = 2'd0;
        scanning      = 1'b0;
        scan_finished = 1'b0;
        pressed       = 1'b0;
    endtask

    // Advances the debounce state by one request and returns its result.
    function automatic t_key_result debounce_step(input logic op, input logic [5:0] keys);
        t_key_result r;
        r = '0;
        if (op == OP_EDGE) begin
            // an edge while a scan runs changes nothing
            if (!scanning) begin
                cand_code     = keys;
                scanning      = 1'b1;
                scan_finished = 1'b0;
                settle_cnt    = pred_cfg.settle_ticks;
                pressed       = (keys != NO_KEY);
                hold_cnt      = 8'd0;
                hold_stage    = 2'd0;
            end
        end else if (keys == cand_code) begin
            if (settle_cnt != 8'd0) begin
                settle_cnt = settle_cnt - 8'd1;
                if (settle_cnt == 8'd0) begin
                    scan_finished = 1'b1;
                    scanning      = 1'b0;
                    if (acc_code != cand_code) begin
                        acc_code       = cand_code;
                        r.code_changed = 1'b1;
                        if (keys == NO_KEY) begin
                            hold_cnt = 8'd0;
                            pressed  = 1'b0;
                        end else begin
                            hold_cnt = pred_cfg.first_hold_ticks;
                            pressed  = 1'b1;
                        end
                    end
                end
            end else if (scan_finished && !scanning && pressed && hold_stage < STAGE_MAX) begin
                if (hold_cnt != 8'd0) begin
                    hold_cnt = hold_cnt - 8'd1;
                    if (hold_cnt == 8'd0) begin
                        hold_stage   = hold_stage + 2'd1;
                        r.hold_event = 1'b1;
                        if (hold_stage == 2'd1) hold_cnt = pred_cfg.second_hold_ticks;
                        else if (hold_stage == 2'd2) hold_cnt = pred_cfg.third_hold_ticks;
                    end
                end
            end
        end else begin
            // bounce: restart settling
            cand_code  = keys;
            settle_cnt = pred_cfg.settle_ticks;
            hold_cnt   = 8'd0;
            hold_stage = 2'd0;
        end
        r.stable_code = acc_code;
        r.hold_level  = hold_stage;
        r.key_down    = pressed;
        r.settled     = scan_finished;
        return r;
    endfunction

    function automatic t_dir_row r_item(input logic op, input logic [5:0] keys);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = op;
        r.keys = keys;
        return r;
    endfunction

    function automatic t_dir_row r_typed(input logic op, input logic [5:0] keys,
                                         input logic [5:0] code, input logic chg,
                                         input logic [1:0] lvl, input logic ev,
                                         input logic down, input logic stl);
        t_dir_row r;
        r                   = r_item(op, keys);
        r.kind              = ROW_TYPED;
        r.want.stable_code  = code;
        r.want.code_changed = chg;
        r.want.hold_level   = lvl;
        r.want.hold_event   = ev;
        r.want.key_down     = down;
        r.want.settled      = stl;
        return r;
    endfunction

    function automatic t_dir_row r_cfg(input int s, input int h1, input int h2, input int h3);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.cfg  = mk_cfg(s, h1, h2, h3);
        return r;
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    task automatic check_result(input t_key_result got);
        t_key_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
        end else begin
            want = expected_results.pop_front();
            if (got.stable_code != want.stable_code)
                report($sformatf("stable_code %h, want %h", got.stable_code, want.stable_code));
            if (got.code_changed != want.code_changed)
                report($sformatf("code_changed %b, want %b", got.code_changed, want.code_changed));
            if (got.hold_level != want.hold_level)
                report($sformatf("hold_level %0d, want %0d", got.hold_level, want.hold_level));
            if (got.hold_event != want.hold_event)
                report($sformatf("hold_event %b, want %b", got.hold_event, want.hold_event));
            if (got.key_down != want.key_down)
                report($sformatf("key_down %b, want %b", got.key_down, want.key_down));
            if (got.settled != want.settled)
                report($sformatf("settled %b, want %b", got.settled, want.settled));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result(t_key_result'(m_axis_tdata));
    end

    // Offers one request, with bursts and random gaps; returns at acceptance.
    task automatic send_request(input logic op, input logic [5:0] keys,
                                input bit typed, input t_key_result want);
        t_key_result predicted;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        items_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_W-6){1'b0}}, keys};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = debounce_step(op, keys);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Stops offering and waits until every result is back.
    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_SETTLE;
        i_cfg_wdata <= c.settle_ticks;
        @(posedge i_clk);
        i_cfg_addr  <= REG_HOLD1;
        i_cfg_wdata <= c.first_hold_ticks;
        @(posedge i_clk);
        i_cfg_addr  <= REG_HOLD2;
        i_cfg_wdata <= c.second_hold_ticks;
        @(posedge i_clk);
        i_cfg_addr  <= REG_HOLD3;
        i_cfg_wdata <= c.third_hold_ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pred_cfg = c;
    endtask

    function automatic logic [5:0] pick_code();
        int         sel;
        logic [5:0] code;
        sel = $urandom_range(0, 9);
        if (sel < 3) code = NO_KEY;
        else if (sel < 7) code = NO_KEY & ~(6'b1 << $urandom_range(0, 5));
        else code = 6'($urandom_range(0, 63));
        return code;
    endfunction

    task automatic send_random(input logic op, input logic [5:0] keys);
        send_request(op, keys, 1'b0, '0);
    endtask

    // Mostly press/hold/release runs with random codes, the rest bounce and noise.
    task automatic run_phase(input t_cfg c, input int n_items, input bit pressure);
        int         roll;
        int         run;
        int         spread;
        int         k;
        int         noise_len;
        bit         bouncy;
        logic       op;
        logic [5:0] code;
        drain_idle();
        write_config(c);
        items_left = n_items;
        if (pressure) begin
            no_gaps      = 1'b1;
            hold_off_req = 1'b1;
        end
        while (items_left > 0) begin
            if (items_left < n_items - 40) no_gaps = 1'b0;
            roll = $urandom_range(0, 9);
            code = pick_code();
            if (roll < 7) begin
                bouncy = ($urandom_range(0, 3) == 0);
                spread = int'(pred_cfg.first_hold_ticks) + int'(pred_cfg.second_hold_ticks)
                       + int'(pred_cfg.third_hold_ticks);
                run = int'(pred_cfg.settle_ticks) + $urandom_range(0, spread + 4);
                // most runs start with an interrupt, some with a plain tick
                send_random(($urandom_range(0, 3) == 0) ? OP_TICK : OP_EDGE, code);
                for (k = 0; k < run && items_left > 0; k++) begin
                    if (bouncy && $urandom_range(0, 7) == 0) send_random(OP_TICK, pick_code());
                    else if (bouncy && $urandom_range(0, 15) == 0) send_random(OP_EDGE, pick_code());
                    else send_random(OP_TICK, code);
                end
            end else begin
                noise_len = $urandom_range(1, 6);
                for (k = 0; k < noise_len && items_left > 0; k++) begin
                    op   = 1'($urandom_range(0, 1));
                    code = 6'($urandom_range(0, 63));
                    send_random(op, code);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver: its own stall pattern, plus one long hold-off on request.
    initial begin : result_sink
        int mode;
        int left;
        bit rdy;
        mode = 0;
        left = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    0, 1:    rdy = 1'b1;
                    2:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ($urandom_range(0, 2) == 0);
                endcase
                m_axis_tready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_dir_row rows [DIR_ROWS];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_SETTLE;
        i_cfg_wdata   = '0;
        debounce_reset();
        rows = '{
            // reset config: first tick restarts settling on no key
            r_typed(OP_TICK, NO_KEY, NO_KEY, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0),
            r_typed(OP_EDGE, 6'h00,  NO_KEY, 1'b0, 2'd0, 1'b0, 1'b1, 1'b0),
            // edge during a scan is ignored
            r_typed(OP_EDGE, NO_KEY, NO_KEY, 1'b0, 2'd0, 1'b0, 1'b1, 1'b0),
            r_cfg(2, 1, 2, 1),
            // changed sample, settle, accept, then climb to hold stage 3 and stay
            r_item(OP_TICK, 6'h2a), r_item(OP_TICK, 6'h2a), r_item(OP_TICK, 6'h2a),
            r_item(OP_TICK, 6'h2a), r_item(OP_TICK, 6'h2a), r_item(OP_TICK, 6'h2a),
            r_item(OP_TICK, 6'h2a), r_item(OP_TICK, 6'h2a),
            r_item(OP_TICK, 6'h15),
            // release to no key
            r_item(OP_TICK, NO_KEY), r_item(OP_TICK, NO_KEY), r_item(OP_TICK, NO_KEY),
            // accepting the same code again: settled, no change pulse
            r_item(OP_EDGE, NO_KEY), r_item(OP_TICK, NO_KEY), r_item(OP_TICK, NO_KEY),
            // zero settle count: never settles
            r_cfg(0, 255, 255, 255),
            r_item(OP_EDGE, 6'h01), r_item(OP_TICK, 6'h01),
            r_item(OP_EDGE, 6'h3e), r_item(OP_TICK, 6'h3e)
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_CFG: begin
                    drain_idle();
                    write_config(rows[i].cfg);
                end
                ROW_TYPED: send_request(rows[i].op, rows[i].keys, 1'b1, rows[i].want);
                default:   send_request(rows[i].op, rows[i].keys, 1'b0, '0);
            endcase
        end

        run_phase(mk_cfg(1, 1, 1, 1), 150, 1'b0);
        run_phase(mk_cfg(1, 255, 1, 255), 250, 1'b0);
        run_phase(mk_cfg($urandom_range(0, 6), $urandom_range(0, 6),
                         $urandom_range(0, 6), $urandom_range(0, 6)), 150, 1'b1);
        run_phase(mk_cfg(255, 2, 2, 2), 150, 1'b0);
        run_phase(mk_cfg($urandom_range(0, 6), $urandom_range(0, 6),
                         $urandom_range(0, 6), $urandom_range(0, 6)), 100, 1'b0);
        run_phase(mk_cfg($urandom_range(1, 12), $urandom_range(1, 12),
                         $urandom_range(1, 12), $urandom_range(1, 12)), 100, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kdmh_pkg.sv
rtl/kdmh_cfg.sv
rtl/kdmh_step.sv
rtl/key_debounce_multi_hold_core.sv
test/tb.sv
